/* rtl/glyph_hash_to_utf16_lookup_defines.svh */
// ----------------------------------------------------------------------------
// glyph hash lookup assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GLYPH_HASH_TO_UTF16_LOOKUP_DEFINES_SVH
`define GLYPH_HASH_TO_UTF16_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// plain condition that must hold at every edge
`define GHUL_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("ghul assertion failed");
// same-cycle implication
`define GHUL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ghul assertion failed");
// next-cycle implication
`define GHUL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ghul assertion failed");
`else
`define GHUL_ASSERT(lbl, expr)
`define GHUL_ASSERT_IMP(lbl, ante, cons)
`define GHUL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/ghul_pkg.sv */
// ----------------------------------------------------------------------------
// ghul_pkg
// shared types and constants of the glyph hash to utf-16 lookup
// ----------------------------------------------------------------------------
package ghul_pkg;

	// request kinds
	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_WBASE  = 2'd1;
	localparam logic [1:0] REQ_WOVER  = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// field widths
	localparam int IDX_W   = 10;
	localparam int HALF_W  = 64;
	localparam int KEY_W   = 128;
	localparam int CP_W    = 21;
	localparam int CNT_W   = 3;
	localparam int UNIT_W  = 16;
	localparam int NUNITS  = 4;
	localparam int CFG_W   = 11;

	// stream payload layout
	localparam int S_DATA_W = 232;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = 2;
	localparam int OFS_IDX  = 0;
	localparam int OFS_HI   = 10;
	localparam int OFS_LO   = 74;
	localparam int OFS_CP   = 138;
	localparam int OFS_CNT  = 159;
	localparam int OFS_UNIT = 162;

	// override table geometry
	localparam int OVER_DEPTH = 16;
	localparam int OW         = 4;

	// utf-16 conversion constants
	localparam logic [CP_W-1:0]   SUPP_BASE = 21'h010000;
	localparam logic [CP_W-1:0]   CP_MAX    = 21'h10FFFF;
	localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
	localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic base_wr;
		logic ov_wr;
		logic ov_clr;
		logic scan_step;
		logic srch_start;
		logic srch_rd;
		logic srch_upd;
		logic out_ov;
		logic out_base;
		logic out_miss;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic ov_hit;
		logic ov_done;
		logic srch_empty;
		logic cmp_eq;
		logic out_done;
	} sts_t;

endpackage

/* rtl/ghul_ctrl.sv */
// ----------------------------------------------------------------------------
// ghul_ctrl
// request sequencer: override scan, binary search probes, output drain
// ----------------------------------------------------------------------------
module ghul_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        req_type,
	input  ghul_pkg::sts_t    sts,
	output ghul_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_SRD  = 3'd2;
	localparam logic [2:0] ST_SCMP = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (req_type)
						ghul_pkg::REQ_LOOKUP: begin
							cmd.capture = 1'b1;
							state_nxt   = ST_SCAN;
						end
						ghul_pkg::REQ_WBASE: cmd.base_wr = 1'b1;
						ghul_pkg::REQ_WOVER: cmd.ov_wr   = 1'b1;
						ghul_pkg::REQ_CLEAR: cmd.ov_clr  = 1'b1;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.ov_hit) begin
					cmd.out_ov = 1'b1;
					state_nxt  = ST_OUT;
				end else if (sts.ov_done) begin
					cmd.srch_start = 1'b1;
					state_nxt      = ST_SRD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_SRD: begin
				if (sts.srch_empty) begin
					cmd.out_miss = 1'b1;
					state_nxt    = ST_OUT;
				end else begin
					cmd.srch_rd = 1'b1;
					state_nxt   = ST_SCMP;
				end
			end
			ST_SCMP: begin
				if (sts.cmp_eq) begin
					cmd.out_base = 1'b1;
					state_nxt    = ST_OUT;
				end else begin
					cmd.srch_upd = 1'b1;
					state_nxt    = ST_SRD;
				end
			end
			ST_OUT: begin
				if (sts.out_done) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* rtl/ghul_dpath.sv */
// ----------------------------------------------------------------------------
// ghul_dpath
// table memories, override scan, search window, utf-16 output buffer
// ----------------------------------------------------------------------------
`include "glyph_hash_to_utf16_lookup_defines.svh"

module ghul_dpath #(
	parameter int BASE_DEPTH = 1024,
	parameter int MAX_UNITS  = 4
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  ghul_pkg::cmd_t                                 cmd,
	output ghul_pkg::sts_t                                 sts,
	input  logic                                           cfg_we,
	input  logic [ghul_pkg::CFG_W-1:0]                     cfg_wdata,
	input  logic [ghul_pkg::IDX_W-1:0]                     in_index,
	input  logic [ghul_pkg::KEY_W-1:0]                     in_key,
	input  logic [ghul_pkg::CP_W-1:0]                      in_code_point,
	input  logic [ghul_pkg::CNT_W-1:0]                     in_unit_count,
	input  logic [ghul_pkg::NUNITS*ghul_pkg::UNIT_W-1:0]   in_units,
	input  logic                                           out_ready,
	output logic                                           out_valid,
	output logic                                           out_found,
	output logic                                           out_from_override,
	output logic [ghul_pkg::UNIT_W-1:0]                    out_code_unit,
	output logic                                           out_last
);

	localparam int AW = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
	localparam int CW = $clog2(BASE_DEPTH + 1);
	localparam int UC = (MAX_UNITS < ghul_pkg::NUNITS) ? MAX_UNITS : ghul_pkg::NUNITS;
	localparam int PW = $clog2(UC);
	localparam int NW = $clog2(UC + 1);
	localparam int UW = UC * ghul_pkg::UNIT_W;
	localparam int KW = ghul_pkg::KEY_W;

	// lookup key and base count
	logic [KW-1:0]              key_q;
	logic [ghul_pkg::CFG_W-1:0] base_cnt_q;
	logic [CW-1:0]              count_eff;

	// base table memory
	logic [KW-1:0]              bm_key   [BASE_DEPTH];
	logic [ghul_pkg::CP_W-1:0]  bm_code  [BASE_DEPTH];
	logic [KW-1:0]              bm_key_s1;
	logic [ghul_pkg::CP_W-1:0]  bm_code_s1;

	// override table memory and marks
	logic [KW-1:0]              om_key   [ghul_pkg::OVER_DEPTH];
	logic [UW-1:0]              om_units [ghul_pkg::OVER_DEPTH];
	logic [NW-1:0]              om_len   [ghul_pkg::OVER_DEPTH];
	logic [ghul_pkg::OVER_DEPTH-1:0] ov_valid_q;
	logic [ghul_pkg::OW-1:0]    ov_slot;
	logic [ghul_pkg::CNT_W-1:0] cnt_sat;
	logic [UW-1:0]              units_w;

	// override scan pipeline
	logic [ghul_pkg::OW-1:0]    scan_q;
	logic                       pend_s1;
	logic                       last_s1;
	logic                       vld_s1;
	logic [KW-1:0]              okey_s1;
	logic [UW-1:0]              ounits_s1;
	logic [NW-1:0]              olen_s1;

	// search window, half open [lo, hix)
	logic [CW-1:0]              lo_q;
	logic [CW-1:0]              hix_q;
	logic [CW:0]                mid_full;
	logic [CW-1:0]              mid_c;
	logic [AW-1:0]              mid_a;
	logic                       cmp_lt;

	// code point conversion
	logic                       is_pair;
	logic [19:0]                supp_v;

	// output buffer
	logic [ghul_pkg::UNIT_W-1:0] obuf_q [UC];
	logic [NW-1:0]              n_q;
	logic [PW-1:0]              pos_q;
	logic                       out_vld_q;
	logic                       found_q;
	logic                       ovr_q;
	logic                       is_last;

	// saturated base count
	assign count_eff = (32'(base_cnt_q) > BASE_DEPTH) ? CW'(BASE_DEPTH) : CW'(base_cnt_q);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cnt_q <= '0;
		end else if (cfg_we) begin
			base_cnt_q <= cfg_wdata;
		end
	end

	// base table write and probe read
	always_ff @(posedge clk) begin
		if (cmd.base_wr && (32'(in_index) < BASE_DEPTH)) begin
			bm_key[AW'(in_index)]  <= in_key;
			bm_code[AW'(in_index)] <= in_code_point;
		end
		if (cmd.srch_rd) begin
			bm_key_s1  <= bm_key[mid_a];
			bm_code_s1 <= bm_code[mid_a];
		end
	end

	// override entry shaping
	assign ov_slot = in_index[ghul_pkg::OW-1:0];
	assign cnt_sat = (in_unit_count > ghul_pkg::CNT_W'(UC)) ? ghul_pkg::CNT_W'(UC)
		: in_unit_count;
	always_comb begin
		for (int i = 0; i < UC; i++) begin
			units_w[i*ghul_pkg::UNIT_W +: ghul_pkg::UNIT_W] =
				(ghul_pkg::CNT_W'(i) < cnt_sat) ?
				in_units[i*ghul_pkg::UNIT_W +: ghul_pkg::UNIT_W] : '0;
		end
	end

	// override table write and scan read
	always_ff @(posedge clk) begin
		if (cmd.ov_wr && (cnt_sat != '0)) begin
			om_key[ov_slot]   <= in_key;
			om_units[ov_slot] <= units_w;
			om_len[ov_slot]   <= NW'(cnt_sat);
		end
		if (cmd.scan_step) begin
			okey_s1   <= om_key[scan_q];
			ounits_s1 <= om_units[scan_q];
			olen_s1   <= om_len[scan_q];
		end
		if (cmd.capture) key_q <= in_key;
	end

	// override marks and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_valid_q <= '0;
			scan_q     <= '0;
			pend_s1    <= 1'b0;
			last_s1    <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			if (cmd.ov_clr) begin
				ov_valid_q <= '0;
			end else if (cmd.ov_wr) begin
				ov_valid_q[ov_slot] <= (cnt_sat != '0);
			end
			pend_s1 <= cmd.scan_step;
			if (cmd.capture) begin
				scan_q <= '0;
			end else if (cmd.scan_step) begin
				scan_q  <= scan_q + 1'b1;
				last_s1 <= (scan_q == ghul_pkg::OW'(ghul_pkg::OVER_DEPTH - 1));
				vld_s1  <= ov_valid_q[scan_q];
			end
		end
	end

	// search midpoint and compare
	assign mid_full = ((CW+1)'(lo_q) + (CW+1)'(hix_q) - (CW+1)'(1)) >> 1;
	assign mid_c    = CW'(mid_full);
	assign mid_a    = AW'(mid_full);
	assign cmp_lt   = key_q < bm_key_s1;

	// search window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= '0;
			hix_q <= '0;
		end else if (cmd.srch_start) begin
			lo_q  <= '0;
			hix_q <= count_eff;
		end else if (cmd.srch_upd) begin
			if (cmp_lt) begin
				hix_q <= mid_c;
			end else begin
				lo_q <= mid_c + CW'(1);
			end
		end
	end

	// surrogate pair split
	assign is_pair = (bm_code_s1 >= ghul_pkg::SUPP_BASE) && (bm_code_s1 <= ghul_pkg::CP_MAX);
	assign supp_v  = 20'(bm_code_s1 - ghul_pkg::SUPP_BASE);
	assign is_last = (NW'(pos_q) + NW'(1)) == n_q;

	// output buffer load and drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			n_q       <= '0;
			pos_q     <= '0;
		end else begin
			if (cmd.out_ov || cmd.out_base || cmd.out_miss) begin
				out_vld_q <= 1'b1;
				pos_q     <= '0;
			end else if (out_vld_q && out_ready) begin
				if (is_last) begin
					out_vld_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (cmd.out_ov) begin
				n_q <= olen_s1;
			end else if (cmd.out_base && is_pair) begin
				n_q <= NW'(2);
			end else if (cmd.out_base || cmd.out_miss) begin
				n_q <= NW'(1);
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.out_ov) begin
			found_q <= 1'b1;
			ovr_q   <= 1'b1;
			for (int i = 0; i < UC; i++) begin
				obuf_q[i] <= ounits_s1[i*ghul_pkg::UNIT_W +: ghul_pkg::UNIT_W];
			end
		end else if (cmd.out_base && is_pair) begin
			found_q   <= 1'b1;
			ovr_q     <= 1'b0;
			obuf_q[0] <= ghul_pkg::HI_SURR + ghul_pkg::UNIT_W'(supp_v[19:10]);
			obuf_q[1] <= ghul_pkg::LO_SURR + ghul_pkg::UNIT_W'(supp_v[9:0]);
		end else if (cmd.out_base && (bm_code_s1 != '0)) begin
			found_q   <= 1'b1;
			ovr_q     <= 1'b0;
			obuf_q[0] <= bm_code_s1[ghul_pkg::UNIT_W-1:0];
		end else if (cmd.out_base || cmd.out_miss) begin
			found_q   <= 1'b0;
			ovr_q     <= 1'b0;
			obuf_q[0] <= '0;
		end
	end

	// status to controller
	assign sts.ov_hit     = pend_s1 && vld_s1 && (okey_s1 == key_q);
	assign sts.ov_done    = pend_s1 && last_s1;
	assign sts.srch_empty = lo_q >= hix_q;
	assign sts.cmp_eq     = key_q == bm_key_s1;
	assign sts.out_done   = out_vld_q && out_ready && is_last;

	assign out_valid         = out_vld_q;
	assign out_found         = found_q;
	assign out_from_override = ovr_q;
	assign out_code_unit     = obuf_q[pos_q];
	assign out_last          = is_last;

	// checks
	`GHUL_ASSERT(a_window_order, lo_q <= hix_q)
	`GHUL_ASSERT_IMP(a_pos_in_range, out_vld_q, (pos_q < n_q) && (n_q != '0))
	`GHUL_ASSERT_IMP(a_no_overrun, cmd.out_ov || cmd.out_base || cmd.out_miss, !out_vld_q)
	`GHUL_ASSERT_NEXT(a_window_shrinks, cmd.srch_upd,
		(hix_q - lo_q) < $past(hix_q - lo_q))

endmodule

/* rtl/glyph_hash_to_utf16_lookup.sv */
// ----------------------------------------------------------------------------
// glyph_hash_to_utf16_lookup
// maps 128-bit glyph digests to utf-16 text via override table and sorted base
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// cfg       in   cfg_we             cfg_wdata = base_count
// s_*       in   s_tvalid/s_tready  tuser = req_type, tdata = entry fields
// m_*       out  m_tvalid/m_tready  tuser = found/from_override, tdata = unit
//
// table writes and clear are done in idle without leaving it; a lookup is
// accepted, scans the override table (one entry per cycle, stopping on a hit),
// then runs a binary search on the base memory port, each probe a read state
// then a compare state (at most clog2(count+1) probes; a miss ends when the
// read state finds the window empty), then sends its units one at a time.
// one item at a time: s_tready is low until the last unit is taken.
// reset clears base_count, the override marks and all control state.
// ----------------------------------------------------------------------------
module glyph_hash_to_utf16_lookup #(
	parameter int BASE_DEPTH = 1024,
	parameter int MAX_UNITS  = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ghul_pkg::CFG_W-1:0]       cfg_wdata,   // base_count
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// index, md5_hi, md5_lo, code_point, unit_count, unit0..unit3, zero pad
	input  logic [ghul_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic [ghul_pkg::S_USER_W-1:0]    s_tuser,     // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ghul_pkg::M_DATA_W-1:0]    m_tdata,     // code_unit
	output logic [ghul_pkg::M_USER_W-1:0]    m_tuser,     // found, from_override
	output logic                             m_tlast      // last
);

	ghul_pkg::cmd_t cmd;
	ghul_pkg::sts_t sts;
	logic           found;
	logic           from_override;

	// sequencer
	ghul_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables and output buffer
	ghul_dpath #(
		.BASE_DEPTH (BASE_DEPTH),
		.MAX_UNITS  (MAX_UNITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_index          (s_tdata[ghul_pkg::OFS_IDX +: ghul_pkg::IDX_W]),
		.in_key            ({s_tdata[ghul_pkg::OFS_HI +: ghul_pkg::HALF_W],
		                     s_tdata[ghul_pkg::OFS_LO +: ghul_pkg::HALF_W]}),
		.in_code_point     (s_tdata[ghul_pkg::OFS_CP +: ghul_pkg::CP_W]),
		.in_unit_count     (s_tdata[ghul_pkg::OFS_CNT +: ghul_pkg::CNT_W]),
		.in_units          (s_tdata[ghul_pkg::OFS_UNIT +:
		                    ghul_pkg::NUNITS*ghul_pkg::UNIT_W]),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.out_found         (found),
		.out_from_override (from_override),
		.out_code_unit     (m_tdata),
		.out_last          (m_tlast)
	);

	// result flags
	assign m_tuser = {from_override, found};

endmodule
